>>> design/qualified_pulse_counter_defines.svh
// Assertion macros used by the pulse counter checker.
`ifndef QUALIFIED_PULSE_COUNTER_DEFINES_SVH
`define QUALIFIED_PULSE_COUNTER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define QPC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qualified_pulse_counter check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define QPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qualified_pulse_counter check failed");

`endif

>>> design/qpc_pkg.sv
// Shared types, codes and widths of the qualified pulse counter.
package qpc_pkg;

	localparam int TIME_W = 63;
	localparam int TOTAL_W = 64;
	localparam int PEND_W = 32;
	localparam int LOST_W = 32;
	localparam int MS_W = 16;
	localparam int US_W = 26;
	localparam int US_PER_MS = 1000;
	localparam int FUNC_W = 3;

	localparam int DEF_PENDING_BITS = 32;
	localparam int DEF_TOTAL_BITS = 64;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int IN_TDATA_W = 128;
	localparam int OUT_TDATA_W = 256;

	localparam int OUT_COUNTED_LSB = 0;
	localparam int OUT_REPORT_LSB = 1;
	localparam int OUT_TOTAL_LSB = 2;
	localparam int OUT_PEND_LSB = OUT_TOTAL_LSB + TOTAL_W;
	localparam int OUT_LOST_LSB = OUT_PEND_LSB + PEND_W;
	localparam int OUT_LAST_LSB = OUT_LOST_LSB + LOST_W;
	localparam int OUT_PREV_LSB = OUT_LAST_LSB + TIME_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_START = 3'd0,
		FN_END   = 3'd1,
		FN_WAKE  = 3'd2,
		FN_TAKE  = 3'd3,
		FN_SET   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE  = 2'd0,
		REG_MIN_WIDTH = 2'd1,
		REG_ENABLE    = 2'd2,
		REG_BLOCK     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [US_W-1:0] debounce_us;
		logic [US_W-1:0] min_width_us;
		logic            active;
	} cfg_t;

endpackage

>>> design/qpc_regs.sv
// APB configuration registers of the qualified pulse counter.
module qpc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [qpc_pkg::DATA_W-1:0]   pwdata,
	output logic [qpc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output qpc_pkg::cfg_t                cfg
);

	logic [qpc_pkg::MS_W-1:0] deb_ms_q;
	logic [qpc_pkg::MS_W-1:0] mwidth_ms_q;
	logic [qpc_pkg::US_W-1:0] debounce_us_q;
	logic [qpc_pkg::US_W-1:0] min_width_us_q;
	logic                     enable_q;
	logic                     block_q;
	logic                     wr_en;
	qpc_pkg::reg_idx_t        idx;
	logic [qpc_pkg::US_W-1:0] wr_us;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = qpc_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_us = qpc_pkg::US_W'(pwdata[qpc_pkg::MS_W-1:0])
		* qpc_pkg::US_W'(qpc_pkg::US_PER_MS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_ms_q <= '0;
			mwidth_ms_q <= '0;
			debounce_us_q <= '0;
			min_width_us_q <= '0;
			enable_q <= 1'b1;
			block_q <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				qpc_pkg::REG_DEBOUNCE: begin
					deb_ms_q <= pwdata[qpc_pkg::MS_W-1:0];
					debounce_us_q <= wr_us;
				end
				qpc_pkg::REG_MIN_WIDTH: begin
					mwidth_ms_q <= pwdata[qpc_pkg::MS_W-1:0];
					min_width_us_q <= wr_us;
				end
				qpc_pkg::REG_ENABLE: enable_q <= pwdata[0];
				qpc_pkg::REG_BLOCK: block_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			qpc_pkg::REG_DEBOUNCE: prdata = qpc_pkg::DATA_W'(deb_ms_q);
			qpc_pkg::REG_MIN_WIDTH: prdata = qpc_pkg::DATA_W'(mwidth_ms_q);
			qpc_pkg::REG_ENABLE: prdata = qpc_pkg::DATA_W'(enable_q);
			qpc_pkg::REG_BLOCK: prdata = qpc_pkg::DATA_W'(block_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.debounce_us = debounce_us_q;
	assign cfg.min_width_us = min_width_us_q;
	assign cfg.active = enable_q && !block_q;

endmodule

>>> design/qpc_core.sv
// Event register, pulse qualification, counter state and result register.
module qpc_core #(
	parameter int PENDING_BITS = qpc_pkg::DEF_PENDING_BITS,
	parameter int TOTAL_BITS = qpc_pkg::DEF_TOTAL_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  qpc_pkg::cfg_t                    cfg,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [qpc_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [qpc_pkg::FUNC_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [qpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int TW = qpc_pkg::TIME_W;

	// input register
	logic                            valid_s1;
	logic [qpc_pkg::FUNC_W-1:0]      func_s1;
	logic [TW-1:0]                   time_s1;
	logic [qpc_pkg::TOTAL_W-1:0]     total_in_s1;

	// result register
	logic                            valid_s2;
	logic [qpc_pkg::OUT_TDATA_W-1:0] data_s2;

	// counter state
	logic [TOTAL_BITS-1:0]           total_q;
	logic [PENDING_BITS-1:0]         pend_q;
	logic [qpc_pkg::LOST_W-1:0]      lost_q;
	logic [TW-1:0]                   last_q;
	logic [TW-1:0]                   prev_q;
	logic [TW-1:0]                   start_q;

	logic                            adv;
	logic [TW:0]                     since_last;
	logic                            spacing_ok;
	logic [TW-1:0]                   width;
	logic                            start_ok;
	logic                            width_ok;
	logic                            hit;
	logic                            take;
	logic                            set;
	logic                            report;
	logic [TOTAL_BITS-1:0]           total_nxt;
	logic [PENDING_BITS-1:0]         pend_upd;
	logic [qpc_pkg::LOST_W-1:0]      lost_upd;
	logic [TW-1:0]                   last_nxt;
	logic [TW-1:0]                   prev_nxt;

	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			time_s1 <= s_tdata[TW-1:0];
			total_in_s1 <= s_tdata[TW +: qpc_pkg::TOTAL_W];
		end
	end

	// qualification
	assign since_last = {1'b0, time_s1} - {1'b0, last_q};
	assign spacing_ok = !since_last[TW] && (since_last[TW-1:0] >= TW'(cfg.debounce_us));
	assign width = time_s1 - start_q;
	assign start_ok = (start_q != '0) && (start_q <= time_s1);
	assign width_ok = (cfg.min_width_us == '0) || (start_ok && (width >= TW'(cfg.min_width_us)));

	always_comb begin
		hit = 1'b0;
		take = 1'b0;
		set = 1'b0;
		unique case (qpc_pkg::func_t'(func_s1))
			qpc_pkg::FN_END: hit = cfg.active && width_ok
				&& ((cfg.debounce_us == '0) || spacing_ok);
			qpc_pkg::FN_WAKE: hit = cfg.active && spacing_ok;
			qpc_pkg::FN_TAKE: take = 1'b1;
			qpc_pkg::FN_SET: set = 1'b1;
			default: ;
		endcase
	end

	// counter updates
	always_comb begin
		total_nxt = total_q;
		pend_upd = pend_q;
		lost_upd = lost_q;
		last_nxt = last_q;
		prev_nxt = prev_q;
		if (set) begin
			total_nxt = total_in_s1[TOTAL_BITS-1:0];
			pend_upd = '0;
			lost_upd = '0;
		end else if (hit) begin
			prev_nxt = last_q;
			last_nxt = time_s1;
			if (!(&total_q)) begin
				total_nxt = total_q + 1'b1;
			end
			if (&pend_q) begin
				if (!(&lost_q)) begin
					lost_upd = lost_q + 1'b1;
				end
			end else begin
				pend_upd = pend_q + 1'b1;
			end
		end
	end

	assign report = take && ((pend_q != '0) || (lost_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pend_q <= '0;
			lost_q <= '0;
			last_q <= '0;
			prev_q <= '0;
			start_q <= '0;
		end else if (adv) begin
			total_q <= total_nxt;
			pend_q <= take ? '0 : pend_upd;
			lost_q <= take ? '0 : lost_upd;
			last_q <= last_nxt;
			prev_q <= prev_nxt;
			if (qpc_pkg::func_t'(func_s1) == qpc_pkg::FN_START) begin
				start_q <= time_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {prev_nxt, last_nxt, lost_upd,
				qpc_pkg::PEND_W'(pend_upd), qpc_pkg::TOTAL_W'(total_nxt), report, hit};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = data_s2;

endmodule

>>> design/qualified_pulse_counter.sv
// Top level of the qualified pulse counter.
// Usage:
// Events enter on the s_ stream: s_tuser carries the event code (start, end,
// wakeup, take report, set total), s_tdata the timestamp and the new total.
// Every event gives exactly one result item on the m_ stream with the
// counted and report flags, the total, pending and lost counts and the last
// two valid pulse times.
// Path: an accepted item is first held in the input register; its result is
// then written into the output register, which drives m_tvalid. Throughput
// is one item per cycle while the receiver does not stall, set by the single
// pass from the input register through the qualification compares and the
// counter increments into the output register.
// When the receiver stalls, the output register holds its item and the input
// register still takes one more item; s_tready then drops until m_tready
// returns.
// Reset clears all counts and times, debounce and minimum width to zero,
// counting to enabled and not blocked. Write the APB registers only while
// no item is in flight.
module qualified_pulse_counter #(
	parameter int PENDING_BITS = qpc_pkg::DEF_PENDING_BITS,
	parameter int TOTAL_BITS = qpc_pkg::DEF_TOTAL_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [qpc_pkg::ADDR_W-1:0]       paddr,
	input  logic [qpc_pkg::DATA_W-1:0]       pwdata,
	output logic [qpc_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// time_us[62:0], total_value[126:63], zero pad [127]
	input  logic [qpc_pkg::IN_TDATA_W-1:0]   s_tdata,
	// func[2:0]
	input  logic [qpc_pkg::FUNC_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// counted[0], has_report[1], total_count[65:2], pending_count[97:66],
	// lost_count[129:98], last_time_us[192:130], prev_time_us[255:193]
	output logic [qpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	qpc_pkg::cfg_t cfg;

	qpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qpc_core #(
		.PENDING_BITS (PENDING_BITS),
		.TOTAL_BITS   (TOTAL_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> design/qpc_checker.sv
// Port-level checker of the qualified pulse counter and its bind.
`include "qualified_pulse_counter_defines.svh"

module qpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [qpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic                            counted;
	logic                            report;
	logic [qpc_pkg::TOTAL_W-1:0]     total;
	logic [qpc_pkg::PEND_W-1:0]      pend;
	logic [qpc_pkg::LOST_W-1:0]      lost;

	assign counted = m_tdata[qpc_pkg::OUT_COUNTED_LSB];
	assign report = m_tdata[qpc_pkg::OUT_REPORT_LSB];
	assign total = m_tdata[qpc_pkg::OUT_TOTAL_LSB +: qpc_pkg::TOTAL_W];
	assign pend = m_tdata[qpc_pkg::OUT_PEND_LSB +: qpc_pkg::PEND_W];
	assign lost = m_tdata[qpc_pkg::OUT_LOST_LSB +: qpc_pkg::LOST_W];

	`QPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`QPC_ASSERT_IMPL(a_stall_only, s_tvalid && !s_tready, m_tvalid && !m_tready)
	`QPC_ASSERT_IMPL(a_counted_total, m_tvalid && counted, total != '0)
	`QPC_ASSERT_IMPL(a_counted_pending, m_tvalid && counted,
		(pend != '0) || (lost != '0) && !report)

endmodule

bind qualified_pulse_counter qpc_checker u_qpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> dv/tb.sv
// Self-checking testbench for the qualified pulse counter: directed and random event streams.
module tb;
	import qpc_pkg::*;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [TIME_W-1:0]  time_us;
		logic [TOTAL_W-1:0] total_value;
	} meter_event_t;

	typedef struct packed {
		logic               counted;
		logic               has_report;
		logic [TOTAL_W-1:0] total;
		logic [PEND_W-1:0]  pending;
		logic [LOST_W-1:0]  lost;
		logic [TIME_W-1:0]  last_us;
		logic [TIME_W-1:0]  prev_us;
	} meter_report_t;

	localparam logic [TOTAL_W-1:0] TOTAL_FULL = '1;
	localparam logic [PEND_W-1:0]  PEND_FULL  = '1;
	localparam logic [LOST_W-1:0]  LOST_FULL  = '1;
	localparam logic [TIME_W-1:0]  TIME_FULL  = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	qualified_pulse_counter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of registers and counter state
	logic [MS_W-1:0]    deb_ms_cfg;
	logic [MS_W-1:0]    mw_ms_cfg;
	logic               cnt_enable;
	logic               cnt_block;
	logic [TOTAL_W-1:0] total_cnt;
	logic [PEND_W-1:0]  pending_cnt;
	logic [LOST_W-1:0]  lost_cnt;
	logic [TIME_W-1:0]  last_pulse_us;
	logic [TIME_W-1:0]  prev_valid_us;
	logic [TIME_W-1:0]  start_us;

	meter_event_t  event_q[$];
	meter_report_t report_q[$];

	int  mismatches = 0;
	bit  in_taken = 0;
	bit  out_taken = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  rx_hold = 0;
	bit  tx_idle_on = 1;
	bit  rx_idle_on = 1;
	logic [TIME_W-1:0] t_now;

	function automatic bit spaced_enough(logic [TIME_W-1:0] t);
		logic [TOTAL_W-1:0] need;
		need = {48'd0, deb_ms_cfg} * 64'(US_PER_MS);
		if (t < last_pulse_us)
			return 1'b0;
		return {1'b0, t - last_pulse_us} >= need;
	endfunction

	function automatic void record_pulse(logic [TIME_W-1:0] t);
		prev_valid_us = last_pulse_us;
		last_pulse_us = t;
		if (total_cnt != TOTAL_FULL)
			total_cnt = total_cnt + 1'b1;
		if (pending_cnt == PEND_FULL) begin
			if (lost_cnt != LOST_FULL)
				lost_cnt = lost_cnt + 1'b1;
		end else begin
			pending_cnt = pending_cnt + 1'b1;
		end
	endfunction

	function automatic meter_report_t count_event(meter_event_t ev);
		meter_report_t r;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] down;
		logic [TOTAL_W-1:0] need;
		logic active;
		logic ok;
		r = '0;
		t = ev.time_us;
		active = cnt_enable && !cnt_block;
		case (ev.func)
			FN_START: start_us = t;
			FN_END: begin
				if (active) begin
					down = (start_us == '0 || start_us > t) ? t : start_us;
					need = {48'd0, mw_ms_cfg} * 64'(US_PER_MS);
					ok = 1'b1;
					if (mw_ms_cfg != '0 && {1'b0, t - down} < need)
						ok = 1'b0;
					if (ok && deb_ms_cfg != '0 && !spaced_enough(t))
						ok = 1'b0;
					if (ok) begin
						record_pulse(t);
						r.counted = 1'b1;
					end
				end
			end
			FN_WAKE: begin
				if (active && spaced_enough(t)) begin
					record_pulse(t);
					r.counted = 1'b1;
				end
			end
			FN_SET: begin
				total_cnt = ev.total_value;
				pending_cnt = '0;
				lost_cnt = '0;
			end
			default: ;
		endcase
		r.total = total_cnt;
		r.pending = pending_cnt;
		r.lost = lost_cnt;
		r.last_us = last_pulse_us;
		r.prev_us = prev_valid_us;
		if (ev.func == FN_TAKE) begin
			r.has_report = (pending_cnt != '0) || (lost_cnt != '0);
			pending_cnt = '0;
			lost_cnt = '0;
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("tb: mismatch %s expected %h got %h", name, want, got);
		end
	endtask

	// sender: holds each item until taken, then waits its drawn gap
	always @(negedge clk) begin
		meter_event_t ev;
		if (arst_n) begin
			if (in_taken)
				tx_gap = tx_idle_on ? $urandom_range(0, 16) : 0;
			if (!s_tvalid || in_taken) begin
				if (tx_gap > 0) begin
					s_tvalid <= 1'b0;
					tx_gap--;
				end else if (event_q.size() > 0) begin
					ev = event_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, ev.total_value, ev.time_us};
					s_tuser <= ev.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
		in_taken = 0;
	end

	// receiver: long hold-off first, then per-item stall
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken)
				rx_gap = rx_idle_on ? $urandom_range(0, 16) : 0;
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap--;
			end else begin
				m_tready <= 1'b1;
			end
		end
		out_taken = 0;
	end

	always @(posedge clk) begin
		meter_event_t ev;
		meter_report_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				out_taken = 1;
				if (report_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: unexpected result %h", m_tdata);
				end else begin
					want = report_q.pop_front();
					check_field("counted", 64'(want.counted), 64'(m_tdata[OUT_COUNTED_LSB]));
					check_field("has_report", 64'(want.has_report),
						64'(m_tdata[OUT_REPORT_LSB]));
					check_field("total_count", want.total, m_tdata[OUT_TOTAL_LSB +: TOTAL_W]);
					check_field("pending_count", 64'(want.pending),
						64'(m_tdata[OUT_PEND_LSB +: PEND_W]));
					check_field("lost_count", 64'(want.lost),
						64'(m_tdata[OUT_LOST_LSB +: LOST_W]));
					check_field("last_time_us", 64'(want.last_us),
						64'(m_tdata[OUT_LAST_LSB +: TIME_W]));
					check_field("prev_time_us", 64'(want.prev_us),
						64'(m_tdata[OUT_PREV_LSB +: TIME_W]));
				end
			end
			if (s_tvalid && s_tready) begin
				in_taken = 1;
				ev.func = s_tuser;
				ev.time_us = s_tdata[TIME_W-1:0];
				ev.total_value = s_tdata[TIME_W +: TOTAL_W];
				report_q.push_back(count_event(ev));
			end
		end
	end

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] near_us(logic [31:0] thr);
		case ($urandom_range(0, 5))
			0: return TIME_W'(thr);
			1: return (thr > 0) ? TIME_W'(thr - 1) : '0;
			2: return TIME_W'(thr) + 1'b1;
			3: return TIME_W'($urandom_range(0, thr * 2 + 10));
			4: return TIME_W'(thr) + TIME_W'($urandom_range(0, 2000));
			default: return TIME_W'($urandom_range(0, 50));
		endcase
	endfunction

	task automatic push_event(logic [FUNC_W-1:0] f, logic [TIME_W-1:0] t,
		logic [TOTAL_W-1:0] tv);
		meter_event_t ev;
		ev.func = f;
		ev.time_us = t;
		ev.total_value = tv;
		event_q.push_back(ev);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEBOUNCE:  deb_ms_cfg = val[MS_W-1:0];
			REG_MIN_WIDTH: mw_ms_cfg = val[MS_W-1:0];
			REG_ENABLE:    cnt_enable = val[0];
			REG_BLOCK:     cnt_block = val[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_idle();
		while (event_q.size() != 0 || s_tvalid || report_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [FUNC_W-1:0] FN_FUNC_UNUSED(int code);
		return FUNC_W'(code);
	endfunction

	task automatic gen_events(int n);
		logic [31:0] w_us;
		logic [31:0] d_us;
		logic [TIME_W-1:0] w;
		logic [TOTAL_W-1:0] tv;
		int r;
		int made;
		w_us = 32'(mw_ms_cfg) * US_PER_MS;
		d_us = 32'(deb_ms_cfg) * US_PER_MS;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				w = near_us(w_us);
				push_event(FN_START, t_now, '0);
				push_event(FN_END, t_now + w, {$urandom, $urandom});
				t_now = t_now + w + near_us(d_us);
				made += 2;
			end else if (r < 77) begin
				push_event(FN_WAKE, t_now, '0);
				t_now = t_now + near_us(d_us);
				made++;
			end else if (r < 85) begin
				push_event(FN_TAKE, rand_time(), {$urandom, $urandom});
				made++;
			end else if (r < 88) begin
				tv = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} :
					TOTAL_FULL - $urandom_range(0, 3);
				push_event(FN_SET, rand_time(), tv);
				made++;
			end else if (r < 91) begin
				push_event(FN_FUNC_UNUSED($urandom_range(5, 7)), rand_time(),
					{$urandom, $urandom});
				made++;
			end else if (r < 97) begin
				// drop in an out-of-order or random timestamp
				w = ($urandom_range(0, 1) != 0) ? t_now - $urandom_range(1, 5000) : rand_time();
				push_event(FUNC_W'($urandom_range(FN_START, FN_WAKE)), w, {$urandom, $urandom});
				made++;
			end else begin
				t_now = rand_time() >> $urandom_range(0, 40);
			end
		end
	endtask

	task automatic run_phase(logic [MS_W-1:0] deb, logic [MS_W-1:0] mw, logic en, logic bl,
		int n, bit tx_idle, bit rx_idle, int hold);
		wait_idle();
		write_reg(REG_DEBOUNCE, DATA_W'(deb));
		write_reg(REG_MIN_WIDTH, DATA_W'(mw));
		write_reg(REG_ENABLE, DATA_W'(en));
		write_reg(REG_BLOCK, DATA_W'(bl));
		tx_idle_on = tx_idle;
		rx_idle_on = rx_idle;
		if (hold > 0) begin
			@(posedge clk);
			rx_hold = hold;
		end
		gen_events(n);
	endtask

	initial begin
		int i;
		deb_ms_cfg = '0;
		mw_ms_cfg = '0;
		cnt_enable = 1'b1;
		cnt_block = 1'b0;
		total_cnt = '0;
		pending_cnt = '0;
		lost_cnt = '0;
		last_pulse_us = '0;
		prev_valid_us = '0;
		start_us = '0;
		t_now = 63'd20000;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: missing and future starts, early wakeup, saturation, unused codes
		push_event(FN_TAKE, '0, '0);
		push_event(FN_END, 63'd1000, '0);
		push_event(FN_START, 63'd5000, '0);
		push_event(FN_END, 63'd8000, '0);
		push_event(FN_WAKE, 63'd7000, '0);
		push_event(FN_WAKE, 63'd8000, '0);
		push_event(FN_TAKE, '0, '0);
		push_event(FN_TAKE, '0, '0);
		push_event(FN_SET, '0, TOTAL_FULL);
		push_event(FN_END, 63'd9000, '0);
		push_event(FN_SET, rand_time(), {$urandom, $urandom});
		push_event(FN_START, TIME_FULL, '0);
		push_event(FN_END, TIME_FULL, TOTAL_FULL);
		push_event(FN_END, 63'd100, '0);
		push_event(FN_START, '0, '0);
		push_event(FN_END, '0, '0);
		push_event(FN_FUNC_UNUSED(5), rand_time(), {$urandom, $urandom});
		push_event(FN_FUNC_UNUSED(6), TIME_FULL, TOTAL_FULL);
		push_event(FN_FUNC_UNUSED(7), rand_time(), {$urandom, $urandom});
		push_event(FN_SET, '0, '0);
		push_event(FN_WAKE, rand_time(), '0);
		push_event(FN_TAKE, TIME_FULL, TOTAL_FULL);

		run_phase(16'd0, 16'd1, 1'b1, 1'b0, 40, 1, 1, 0);
		run_phase(16'd1, 16'd0, 1'b1, 1'b0, 40, 1, 1, 0);
		run_phase(16'd3, 16'd2, 1'b1, 1'b0, 40, 0, 1, 80);
		run_phase(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 40, 1, 1, 0);
		run_phase(16'd0, 16'hFFFF, 1'b1, 1'b0, 40, 1, 0, 0);
		run_phase(16'd2, 16'd1, 1'b0, 1'b0, 40, 1, 1, 0);
		run_phase(16'd2, 16'd1, 1'b1, 1'b1, 40, 1, 1, 0);
		run_phase(MS_W'($urandom_range(0, 20)), MS_W'($urandom_range(0, 20)), 1'b1, 1'b0,
			40, 0, 0, 0);
		run_phase(MS_W'($urandom), MS_W'($urandom), 1'b1, 1'b0, 40, 1, 1, 0);
		run_phase(16'd5, 16'd0, 1'b1, 1'b0, 40, 1, 1, 40);
		run_phase(16'd0, 16'd0, 1'b1, 1'b0, 40, 1, 1, 0);

		while (event_q.size() != 0 || s_tvalid)
			@(posedge clk);
		for (i = 0; i < 2000 && report_q.size() != 0; i++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0 && report_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("tb: FAIL");
		$finish;
	end

endmodule
